@@ rtl/s2tw_pkg.sv @@
// Shared types and constants of the stage-2 table walker.
package s2tw_pkg;

  // Field widths
  localparam int PAGE_W      = 36;
  localparam int IPN_W       = 27;
  localparam int WIDX_W      = 12;
  localparam int WORD_W      = 64;
  localparam int STATUS_W    = 3;
  localparam int IDX_W       = 9;
  localparam int CFG_ADDR_W  = 1;
  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 72;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_ROOT = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_BASE = 1'b1;

  // Input item kinds
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_XLATE = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_FOUND   = 3'd0;
  localparam logic [STATUS_W-1:0] ST_NO_ROOT = 3'd1;
  localparam logic [STATUS_W-1:0] ST_L1_BAD  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_L2_BAD  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_OUTSIDE = 3'd4;

  // Walk level, selects the index bits of the page number
  typedef enum logic [1:0] {
    LVL_1,
    LVL_2,
    LVL_3
  } lvl_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic                clr_en;
    logic                wr_en;
    logic                start;
    logic                rd_en;
    logic                page_sel_entry;
    lvl_t                lvl;
    logic                res_load;
    logic                res_mem;
    logic [STATUS_W-1:0] res_status;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic clr_last;
    logic root_none;
    logic page_out;
    logic desc_bad;
  } stat_t;

endpackage

@@ rtl/s2tw_datapath.sv @@
// Datapath of the walker: table store, configuration, page checks and result register.
module s2tw_datapath #(
  parameter int STORE_PAGES = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  s2tw_pkg::cmd_t                      cmd,
  output s2tw_pkg::stat_t                     stat,
  input  logic                                cfg_we,
  input  logic [s2tw_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [s2tw_pkg::PAGE_W-1:0]         cfg_wdata,
  input  logic [s2tw_pkg::IPN_W-1:0]          in_ipn,
  input  logic [s2tw_pkg::WIDX_W-1:0]         in_word_index,
  input  logic [s2tw_pkg::WORD_W-1:0]         in_word_data,
  output logic [s2tw_pkg::WORD_W-1:0]         out_entry,
  output logic [s2tw_pkg::STATUS_W-1:0]       out_status
);

  localparam int SLOT_W      = (STORE_PAGES > 1) ? $clog2(STORE_PAGES) : 1;
  localparam int ADDR_W      = SLOT_W + s2tw_pkg::IDX_W;
  localparam int STORE_WORDS = STORE_PAGES * 512;
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_WORDS - 1);

  logic [s2tw_pkg::PAGE_W-1:0]   root_page_r;
  logic [s2tw_pkg::PAGE_W-1:0]   base_page_r;
  logic [s2tw_pkg::IPN_W-1:0]    ipn_r;
  logic [ADDR_W-1:0]             clr_cnt_r;
  logic [s2tw_pkg::WORD_W-1:0]   rdata_r;
  logic [s2tw_pkg::WORD_W-1:0]   out_entry_r;
  logic [s2tw_pkg::STATUS_W-1:0] out_status_r;
  logic [s2tw_pkg::WORD_W-1:0]   mem [STORE_WORDS];

  logic [s2tw_pkg::PAGE_W-1:0]   page_cand;
  logic [s2tw_pkg::PAGE_W:0]     page_diff;
  logic [s2tw_pkg::IDX_W-1:0]    lvl_idx;
  logic [ADDR_W-1:0]             raddr;
  logic                          mem_we;
  logic [ADDR_W-1:0]             waddr;
  logic [s2tw_pkg::WORD_W-1:0]   wdata;

  // Configuration registers and clear counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      root_page_r <= '0;
      base_page_r <= '0;
      clr_cnt_r   <= '0;
    end else begin
      if (cfg_we && cfg_addr == s2tw_pkg::CFG_ROOT) begin
        root_page_r <= cfg_wdata;
      end
      if (cfg_we && cfg_addr == s2tw_pkg::CFG_BASE) begin
        base_page_r <= cfg_wdata;
      end
      if (cmd.clr_en) begin
        clr_cnt_r <= clr_cnt_r + ADDR_W'(1);
      end
    end
  end

  // Page number of the translation in flight
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      ipn_r <= in_ipn;
    end
  end

  // Table page under check: the root, or the next page named by the last entry
  always_comb begin
    page_cand = cmd.page_sel_entry ? rdata_r[47:12] : root_page_r;
    page_diff = {1'b0, page_cand} - {1'b0, base_page_r};
  end

  // Entry index for the current level
  always_comb begin
    case (cmd.lvl)
      s2tw_pkg::LVL_1: lvl_idx = ipn_r[26:18];
      s2tw_pkg::LVL_2: lvl_idx = ipn_r[17:9];
      s2tw_pkg::LVL_3: lvl_idx = ipn_r[8:0];
      default:         lvl_idx = ipn_r[8:0];
    endcase
  end

  assign raddr = {page_diff[SLOT_W-1:0], lvl_idx};

  // Status back to the controller
  always_comb begin
    stat.clr_last  = (clr_cnt_r == LAST_ADDR);
    stat.root_none = (root_page_r == '0);
    stat.page_out  = page_diff[s2tw_pkg::PAGE_W] ||
                     (page_diff[s2tw_pkg::PAGE_W-1:0] >= s2tw_pkg::PAGE_W'(STORE_PAGES));
    stat.desc_bad  = (rdata_r[1:0] != 2'b11);
  end

  // Write side of the store: clear pass or a write beat within the store
  always_comb begin
    mem_we = cmd.clr_en || (cmd.wr_en && (32'(in_word_index) < STORE_WORDS));
    waddr  = cmd.clr_en ? clr_cnt_r : ADDR_W'(in_word_index);
    wdata  = cmd.clr_en ? '0 : in_word_data;
  end

  // Table store with registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd_en) begin
      rdata_r <= mem[raddr];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_entry_r  <= cmd.res_mem ? rdata_r : '0;
      out_status_r <= cmd.res_status;
    end
  end

  assign out_entry  = out_entry_r;
  assign out_status = out_status_r;

endmodule

@@ rtl/s2tw_ctrl.sv @@
// Controller of the walker: clear pass, item intake, level sequencing and output valid.
module s2tw_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  input  logic            in_mode,
  output logic            in_tready,
  output logic            out_tvalid,
  input  logic            out_tready,
  output s2tw_pkg::cmd_t  cmd,
  input  s2tw_pkg::stat_t stat
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WALK1,
    S_CHK1,
    S_CHK2,
    S_CHK3
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || out_tready;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.lvl   = s2tw_pkg::LVL_1;
    in_tready = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_en = 1'b1;
        if (stat.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          if (in_mode == s2tw_pkg::MODE_WRITE) begin
            cmd.wr_en = 1'b1;
          end else begin
            cmd.start = 1'b1;
            state_nxt = S_WALK1;
          end
        end
      end
      S_WALK1: begin
        cmd.lvl = s2tw_pkg::LVL_1;
        if (stat.root_none) begin
          if (out_free) begin
            cmd.res_load   = 1'b1;
            cmd.res_status = s2tw_pkg::ST_NO_ROOT;
            state_nxt      = S_IDLE;
          end
        end else if (stat.page_out) begin
          if (out_free) begin
            cmd.res_load   = 1'b1;
            cmd.res_status = s2tw_pkg::ST_OUTSIDE;
            state_nxt      = S_IDLE;
          end
        end else begin
          cmd.rd_en = 1'b1;
          state_nxt = S_CHK1;
        end
      end
      S_CHK1: begin
        cmd.page_sel_entry = 1'b1;
        cmd.lvl            = s2tw_pkg::LVL_2;
        if (stat.desc_bad) begin
          if (out_free) begin
            cmd.res_load   = 1'b1;
            cmd.res_status = s2tw_pkg::ST_L1_BAD;
            state_nxt      = S_IDLE;
          end
        end else if (stat.page_out) begin
          if (out_free) begin
            cmd.res_load   = 1'b1;
            cmd.res_status = s2tw_pkg::ST_OUTSIDE;
            state_nxt      = S_IDLE;
          end
        end else begin
          cmd.rd_en = 1'b1;
          state_nxt = S_CHK2;
        end
      end
      S_CHK2: begin
        cmd.page_sel_entry = 1'b1;
        cmd.lvl            = s2tw_pkg::LVL_3;
        if (stat.desc_bad) begin
          if (out_free) begin
            cmd.res_load   = 1'b1;
            cmd.res_status = s2tw_pkg::ST_L2_BAD;
            state_nxt      = S_IDLE;
          end
        end else if (stat.page_out) begin
          if (out_free) begin
            cmd.res_load   = 1'b1;
            cmd.res_status = s2tw_pkg::ST_OUTSIDE;
            state_nxt      = S_IDLE;
          end
        end else begin
          cmd.rd_en = 1'b1;
          state_nxt = S_CHK3;
        end
      end
      S_CHK3: begin
        if (out_free) begin
          cmd.res_load   = 1'b1;
          cmd.res_mem    = 1'b1;
          cmd.res_status = s2tw_pkg::ST_FOUND;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Output valid follows loads and taken beats
  always_comb begin
    if (cmd.res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // State and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

@@ rtl/stage2_table_walker.sv @@
// Top level of the three-level stage-2 table walker with a local table store.
//
// After reset the block clears all STORE_PAGES * 512 words of its table
// store, one word a cycle, and takes no input beat until that is done;
// configuration writes are taken throughout. A write beat (tuser 0) stores
// one word and returns nothing. A translate beat (tuser 1) walks three
// levels, one registered read of the store per level, through S_WALK1,
// S_CHK1, S_CHK2 and S_CHK3, or goes back to idle from an early check that
// stops it; no input beat is taken until the walk is back in idle. The
// result sits in an output register, so the next beat is taken while it
// waits; a walk that finishes while the previous result is still unread
// holds until that beat is taken.
module stage2_table_walker #(
  parameter int STORE_PAGES = 8
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Configuration write port
  input  logic                                 cfg_we,
  input  logic [s2tw_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  logic [s2tw_pkg::PAGE_W-1:0]          cfg_wdata,
  // Input channel
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // tdata: ipn[26:0], word_index[38:27], word_data[102:39], zero pad[103]
  input  logic [s2tw_pkg::IN_TDATA_W-1:0]      in_tdata,
  // tuser: mode[0]
  input  logic                                 in_tuser,
  // Result channel
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // tdata: entry[63:0], status[66:64], zero pad[71:67]
  output logic [s2tw_pkg::OUT_TDATA_W-1:0]     out_tdata
);

  s2tw_pkg::cmd_t                cmd;
  s2tw_pkg::stat_t               stat;
  logic [s2tw_pkg::WORD_W-1:0]   out_entry;
  logic [s2tw_pkg::STATUS_W-1:0] out_status;

  s2tw_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_mode    (in_tuser),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .stat       (stat)
  );

  s2tw_datapath #(
    .STORE_PAGES (STORE_PAGES)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .in_ipn        (in_tdata[26:0]),
    .in_word_index (in_tdata[38:27]),
    .in_word_data  (in_tdata[102:39]),
    .out_entry     (out_entry),
    .out_status    (out_status)
  );

  // Pack the result beat
  assign out_tdata = {5'b0, out_status, out_entry};

`ifndef SYNTHESIS
  // A result is loaded only into a free or draining output register.
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_load |-> (!out_tvalid || out_tready))
    else $error("result loaded over an untaken beat");

  // Reset starts the clear pass, during which no input beat is taken.
  a_clear_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("input taken right after reset");

  // A delivered status is always one of the defined codes.
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[66:64] <= s2tw_pkg::ST_OUTSIDE))
    else $error("undefined status code");

  // Store reads and writes of input beats never overlap the clear pass.
  a_clear_alone: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr_en |-> (!cmd.rd_en && !cmd.wr_en && !in_tready))
    else $error("store access during clear pass");
`endif

endmodule

@@ dv/stage2_table_walker_tb.sv @@
// Self-checking testbench for the three-level stage-2 table walker.
`timescale 1ns / 1ps

module stage2_table_walker_tb;

  localparam int PAGE_W      = s2tw_pkg::PAGE_W;
  localparam int IPN_W       = s2tw_pkg::IPN_W;
  localparam int WIDX_W      = s2tw_pkg::WIDX_W;
  localparam int WORD_W      = s2tw_pkg::WORD_W;
  localparam int STATUS_W    = s2tw_pkg::STATUS_W;
  localparam int IDX_W       = s2tw_pkg::IDX_W;
  localparam int CFG_ADDR_W  = s2tw_pkg::CFG_ADDR_W;
  localparam int IN_TDATA_W  = s2tw_pkg::IN_TDATA_W;
  localparam int OUT_TDATA_W = s2tw_pkg::OUT_TDATA_W;

  localparam int STORE_PAGES    = 8;
  localparam int WORDS_PER_PAGE = 512;
  localparam int STORE_WORDS    = STORE_PAGES * WORDS_PER_PAGE;
  localparam int SETTLE_CYCLES  = 16;
  localparam int LONG_HOLD      = 400;
  localparam int RANDOM_PHASES  = 9;
  localparam int PHASE_ITEMS    = 170;
  localparam longint LIMIT_NS   = 2_000_000;

  localparam logic [PAGE_W-1:0] PAGE_MAX = '1;

  // Descriptor type bits 1:0
  localparam logic [1:0] DESC_TABLE    = 2'b11;
  localparam logic [1:0] DESC_BLOCK    = 2'b01;
  localparam logic [1:0] DESC_RESERVED = 2'b10;

  typedef struct packed {
    logic [WORD_W-1:0]   entry;
    logic [STATUS_W-1:0] status;
  } walk_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   cfg_we;
  logic [CFG_ADDR_W-1:0]  cfg_addr;
  logic [PAGE_W-1:0]      cfg_wdata;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic                   in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;

  // Mirror of the block's state
  bit   [WORD_W-1:0] table_mirror [STORE_WORDS];
  logic [PAGE_W-1:0] root_page = '0;
  logic [PAGE_W-1:0] base_page = '0;

  walk_result_t pending_walks[$];
  walk_result_t seen_walk;
  int           error_count  = 0;
  bit           idle_on      = 1'b1;
  bit           hold_request = 1'b0;

  stage2_table_walker #(
    .STORE_PAGES(STORE_PAGES)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always #1 clk = ~clk;

  // Maps a physical page to its store slot; false when outside the store.
  function automatic bit page_in_store(input logic [PAGE_W-1:0] page, output int slot);
    logic [PAGE_W-1:0] offs;
    offs = page - base_page;
    slot = int'(offs[15:0]);
    return (page >= base_page) && (offs < STORE_PAGES);
  endfunction

  // Three-level walk over the mirror, first failing check decides the status.
  function automatic walk_result_t predict_walk(input logic [IPN_W-1:0] ipn);
    walk_result_t r;
    int           slot;
    logic [WORD_W-1:0] desc;
    r.entry = '0;
    if (root_page == '0) begin
      r.status = s2tw_pkg::ST_NO_ROOT;
      return r;
    end
    if (!page_in_store(root_page, slot)) begin
      r.status = s2tw_pkg::ST_OUTSIDE;
      return r;
    end
    desc = table_mirror[slot * WORDS_PER_PAGE + int'(ipn[26:18])];
    if (desc[1:0] != DESC_TABLE) begin
      r.status = s2tw_pkg::ST_L1_BAD;
      return r;
    end
    if (!page_in_store(desc[47:12], slot)) begin
      r.status = s2tw_pkg::ST_OUTSIDE;
      return r;
    end
    desc = table_mirror[slot * WORDS_PER_PAGE + int'(ipn[17:9])];
    if (desc[1:0] != DESC_TABLE) begin
      r.status = s2tw_pkg::ST_L2_BAD;
      return r;
    end
    if (!page_in_store(desc[47:12], slot)) begin
      r.status = s2tw_pkg::ST_OUTSIDE;
      return r;
    end
    r.entry  = table_mirror[slot * WORDS_PER_PAGE + int'(ipn[8:0])];
    r.status = s2tw_pkg::ST_FOUND;
    return r;
  endfunction

  // Descriptor pointing at a page, random in the bits the walk ignores.
  function automatic logic [WORD_W-1:0] desc_of(input logic [PAGE_W-1:0] page,
                                                 input logic [1:0] kind);
    logic [WORD_W-1:0] d;
    d        = {$urandom, $urandom};
    d[47:12] = page;
    d[1:0]   = kind;
    return d;
  endfunction

  function automatic logic [PAGE_W-1:0] rand_page();
    return PAGE_W'({$urandom, $urandom});
  endfunction

  function automatic logic [WIDX_W-1:0] word_at(input int slot, input logic [IDX_W-1:0] idx);
    return WIDX_W'(slot * WORDS_PER_PAGE + int'(idx));
  endfunction

  function automatic int pick_gap();
    int sel;
    if (!idle_on) return 0;
    sel = $urandom_range(0, 99);
    if (sel < 50) return 0;
    if (sel < 85) return $urandom_range(1, 3);
    if (sel < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic flag_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("ERROR at %0t ns: %s", $time, msg);
  endtask

  // Offers one beat and updates the mirror when it is taken. The valid stays
  // high when the next beat follows without a gap.
  task automatic send_beat(input logic mode, input logic [IPN_W-1:0] ipn,
                           input logic [WIDX_W-1:0] widx, input logic [WORD_W-1:0] wdata);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, wdata, widx, ipn};
    in_tuser  <= mode;
    do @(posedge clk); while (!in_tready);
    if (mode == s2tw_pkg::MODE_WRITE) begin
      if (widx < STORE_WORDS) table_mirror[widx] = wdata;
    end else begin
      pending_walks.push_back(predict_walk(ipn));
    end
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Unused fields carry random values on both beat kinds.
  task automatic send_write(input logic [WIDX_W-1:0] widx, input logic [WORD_W-1:0] wdata);
    send_beat(s2tw_pkg::MODE_WRITE, IPN_W'($urandom), widx, wdata);
  endtask

  task automatic send_xlate(input logic [IPN_W-1:0] ipn);
    send_beat(s2tw_pkg::MODE_XLATE, ipn, WIDX_W'($urandom), {$urandom, $urandom});
  endtask

  // Drains all walks, then lets a walk-free write settle.
  task automatic wait_for_idle();
    in_tvalid <= 1'b0;
    while (pending_walks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // One register write; the caller drops the write enable after its last write.
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [PAGE_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= value;
    @(posedge clk);
    case (addr)
      s2tw_pkg::CFG_ROOT: root_page = value;
      s2tw_pkg::CFG_BASE: base_page = value;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [PAGE_W-1:0] root, input logic [PAGE_W-1:0] base);
    wait_for_idle();
    write_reg(s2tw_pkg::CFG_BASE, base);
    write_reg(s2tw_pkg::CFG_ROOT, root);
    cfg_we <= 1'b0;
  endtask

  // No root after reset, then a root into the freshly cleared store.
  task automatic test_after_reset();
    logic [PAGE_W-1:0] b;
    send_xlate(IPN_W'($urandom));
    b = rand_page() | 1;
    set_config(b, b);
    send_xlate(IPN_W'($urandom));
  endtask

  // Hand-built chains covering every status and the field extremes.
  task automatic test_directed_walks();
    logic [PAGE_W-1:0] b;
    b = PAGE_W'($urandom) | PAGE_W'(1);
    set_config(b + 2, b);
    send_write(word_at(2, 9'h1FF), desc_of(b + 5, DESC_TABLE));
    send_write(word_at(5, 9'h000), desc_of(b + 7, DESC_TABLE));
    send_write(word_at(7, 9'h1FF), '1);
    send_write(word_at(0, 9'h000), '0);
    send_xlate({9'h1FF, 9'h000, 9'h1FF});
    send_xlate({9'h1FF, 9'h000, 9'h000});
    // Level 1 entry missing, then a block and a reserved type
    send_xlate('0);
    send_write(word_at(2, 9'h000), desc_of(b + 5, DESC_BLOCK));
    send_xlate({9'h000, 9'h1FF, 9'h1FF});
    send_write(word_at(2, 9'h003), desc_of(b + 5, DESC_RESERVED));
    send_xlate({9'h003, 9'h000, 9'h000});
    // Level 2 entry with the wrong type
    send_write(word_at(5, 9'h001), desc_of(b + 7, DESC_RESERVED));
    send_xlate({9'h1FF, 9'h001, 9'h1FF});
    // Level 2 table page past the end and below the start of the store
    send_write(word_at(2, 9'h001), desc_of(b + STORE_PAGES, DESC_TABLE));
    send_xlate({9'h001, 9'h000, 9'h000});
    send_write(word_at(2, 9'h002), desc_of(b - 1, DESC_TABLE));
    send_xlate({9'h002, 9'h000, 9'h000});
    // Level 3 table page outside the store
    send_write(word_at(5, 9'h002), desc_of(b + STORE_PAGES, DESC_TABLE));
    send_xlate({9'h1FF, 9'h002, 9'h1FF});
    send_xlate('1);
    // Root outside the store on both sides, then no root
    set_config(b + STORE_PAGES, b);
    send_xlate({9'h1FF, 9'h000, 9'h1FF});
    set_config(b - 1, b);
    send_xlate({9'h1FF, 9'h000, 9'h1FF});
    set_config('0, b);
    send_xlate({9'h1FF, 9'h000, 9'h1FF});
    // Highest page numbers: every level lands in the first store page
    set_config(PAGE_MAX, PAGE_MAX);
    send_write(word_at(0, 9'h003), desc_of(PAGE_MAX, DESC_TABLE));
    send_write(word_at(0, 9'h004), desc_of(PAGE_MAX, DESC_TABLE));
    send_write(word_at(0, 9'h005), {$urandom, $urandom});
    send_xlate({9'h003, 9'h004, 9'h005});
  endtask

  // One setting of the registers, then mostly well-formed table building
  // mixed with walks over a small set of indexes so that walks go deep.
  task automatic test_random_tables(input int phase, input int n_items);
    logic [PAGE_W-1:0]   b;
    logic [PAGE_W-1:0]   r;
    logic [IDX_W-1:0]    pool [6];
    logic [IDX_W-1:0]    idx;
    logic [WORD_W-1:0]   data;
    logic [IPN_W-1:0]    ipn;
    logic [PAGE_W-1:0]   offs;
    int                  slots [3];
    int                  k;
    int                  sel;
    int                  slot;
    if (phase == 0) b = '0;
    else if (phase == 1) b = PAGE_MAX - (STORE_PAGES - 1);
    else b = rand_page();
    sel = $urandom_range(0, 19);
    if (phase == 0) r = PAGE_W'($urandom_range(1, STORE_PAGES - 1));
    else if (sel == 0) r = '0;
    else if (sel <= 2) r = b + STORE_PAGES + $urandom_range(0, 3);
    else if (sel == 3) r = b - 1 - $urandom_range(0, 3);
    else r = b + $urandom_range(0, STORE_PAGES - 1);
    set_config(r, b);
    offs = r - b;
    slots[0] = (offs < STORE_PAGES) ? int'(offs[15:0]) : $urandom_range(0, STORE_PAGES - 1);
    slots[1] = $urandom_range(0, STORE_PAGES - 1);
    slots[2] = $urandom_range(0, STORE_PAGES - 1);
    pool[0] = '0;
    pool[1] = '1;
    for (k = 2; k < 6; k++) pool[k] = IDX_W'($urandom);
    for (k = 0; k < n_items; k++) begin
      if ($urandom_range(0, 99) < 45) begin
        idx  = ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, 5)] : IDX_W'($urandom);
        slot = ($urandom_range(0, 99) < 80) ? slots[$urandom_range(0, 2)]
                                             : $urandom_range(0, STORE_PAGES - 1);
        sel  = $urandom_range(0, 99);
        if (sel < 70) data = desc_of(b + slots[$urandom_range(0, 2)], DESC_TABLE);
        else if (sel < 78) data = desc_of(b + $urandom_range(0, STORE_PAGES - 1), DESC_TABLE);
        else if (sel < 85) data = desc_of(rand_page(), DESC_TABLE);
        else data = {$urandom, $urandom};
        send_write(word_at(slot, idx), data);
      end else begin
        if ($urandom_range(0, 99) < 80)
          ipn = {pool[$urandom_range(0, 5)], pool[$urandom_range(0, 5)],
                 pool[$urandom_range(0, 5)]};
        else
          ipn = IPN_W'($urandom);
        send_xlate(ipn);
      end
    end
  endtask

  // The receiver holds off while walks keep coming, so the input stalls.
  task automatic test_output_backpressure();
    int k;
    idle_on      = 1'b0;
    hold_request = 1'b1;
    for (k = 0; k < 60; k++) send_xlate(IPN_W'($urandom));
    idle_on = 1'b1;
  endtask

  // Result side ready: random runs, a long hold on request, or always ready.
  initial begin : ready_driver
    int  run_left;
    int  sel;
    bit  level;
    out_tready <= 1'b0;
    run_left = 0;
    level    = 1'b1;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_tready <= 1'b0;
        for (int c = 1; c < LONG_HOLD; c++) @(posedge clk);
        run_left = 0;
      end else if (!idle_on) begin
        out_tready <= 1'b1;
      end else begin
        if (run_left == 0) begin
          sel      = $urandom_range(0, 99);
          level    = (sel < 70);
          run_left = (sel % 20 == 0) ? $urandom_range(30, 80) : $urandom_range(1, 6);
        end
        out_tready <= level;
        run_left--;
      end
    end
  end

  // Each result beat against the oldest predicted walk.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_walks.size() == 0) begin
        flag_error($sformatf("result beat with no walk pending: %h", out_tdata));
      end else begin
        seen_walk = pending_walks.pop_front();
        if (out_tdata[WORD_W-1:0] !== seen_walk.entry)
          flag_error($sformatf("entry expected %h, got %h", seen_walk.entry,
                               out_tdata[WORD_W-1:0]));
        if (out_tdata[WORD_W +: STATUS_W] !== seen_walk.status)
          flag_error($sformatf("status expected %0d, got %0d", seen_walk.status,
                               out_tdata[WORD_W +: STATUS_W]));
      end
    end
  end

  // Main sequence
  initial begin
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_addr  <= s2tw_pkg::CFG_ROOT;
    cfg_wdata <= '0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= s2tw_pkg::MODE_WRITE;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_after_reset();
    test_directed_walks();
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      idle_on = (p % 3 != 2);
      test_random_tables(p, PHASE_ITEMS);
    end
    idle_on = 1'b1;
    test_output_backpressure();
    wait_for_idle();
    if (error_count == 0 && pending_walks.size() == 0) begin
      $display("stage2_table_walker test passed");
    end else begin
      $display("stage2_table_walker test failed");
    end
    $finish;
  end

  // Run limit
  initial begin
    #(LIMIT_NS);
    $display("stage2_table_walker test failed");
    $finish;
  end

endmodule
